// ===== sv/sac_pkg.sv =====
// Shared types, widths and constants for the swept box collision pipeline.
`default_nettype none
package sac_pkg;

  localparam int POS_W  = 32;
  localparam int SIZE_W = 16;
  localparam int FRAC_W = 16;
  localparam int DIST_W = 35;
  localparam int TIME_W = 32;
  localparam int ET_W   = 17;
  localparam int QBITS  = 33;
  localparam int NUM_W  = 50;
  localparam int DEN_W  = 32;
  localparam int HIGH_W = NUM_W - QBITS;
  localparam int DIV_LAT = QBITS + 2;
  localparam int PIPE_DEPTH = DIV_LAT + 3;
  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [TIME_W-1:0] T_MIN   = 32'sh8000_0000;
  localparam logic signed [TIME_W-1:0] T_MAX   = 32'sh7fff_ffff;
  localparam logic signed [TIME_W-1:0] FIX_ONE = 32'sh0001_0000;

  localparam logic [1:0] NRM_ZERO = 2'b00;
  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;

  typedef struct packed {
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
    logic [SIZE_W-1:0]       mw;
    logic [SIZE_W-1:0]       mh;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic [SIZE_W-1:0]       bw;
    logic [SIZE_W-1:0]       bh;
  } pair_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] din;
    logic signed [DIST_W-1:0] dout;
    logic signed [POS_W-1:0]  vel;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    logic  broad;
  } front_t;

  typedef struct packed {
    logic broad;
    logic din_x_neg;
    logic din_y_neg;
  } side_t;

  typedef struct packed {
    logic              hit;
    logic [ET_W-1:0]   entry_time;
    logic [1:0]        normal_x;
    logic [1:0]        normal_y;
    logic              broad_overlap;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/swept_aabb_collision.sv =====
// Top level of the pipelined 2D swept box collision test.
//
// Each transaction on the s_axis channel carries one pair: a moving box with its
// displacement for one frame and a static box. For each pair one transaction
// leaves on m_axis with the swept-test answer (hit flag, Q1.16 entry time,
// per-axis contact normal) and the broad-phase overlap of the swept bounds.
//
// The pair goes through an input register, an edge-distance stage, four
// parallel dividers of 35 stages each (one quotient bit per stage, plus an
// operand stage and a saturation stage) and a decision stage. Throughput is
// one pair per cycle while the receiver takes results, set by the
// one-bit-per-stage divider pipelines.
//
// All stages advance together whenever the output register is empty or being
// taken. When the receiver stalls with a result waiting, the whole pipeline
// holds and s_axis_tready drops; no pair is lost or repeated.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
`default_nettype none
module swept_aabb_collision import sac_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // mover_x, mover_y, mover_width, mover_height, mover_vel_x, mover_vel_y,
  // block_x, block_y, block_width, block_height (lowest bits first)
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // hit, entry_time, normal_x, normal_y, broad_overlap, zero pad (lowest first)
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  logic [PIPE_DEPTH-1:0] vld;
  logic   en;
  pair_t  pair;
  front_t front;
  side_t  side_line [DIV_LAT];
  logic signed [TIME_W-1:0] ex;
  logic signed [TIME_W-1:0] ey;
  logic signed [TIME_W-1:0] xx;
  logic signed [TIME_W-1:0] xy;
  res_t   res;

  // The pipeline moves as one unit; the last stage is the output register.
  assign en            = !vld[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en) begin
      pair.mx <= s_axis_tdata[31:0];
      pair.my <= s_axis_tdata[63:32];
      pair.mw <= s_axis_tdata[79:64];
      pair.mh <= s_axis_tdata[95:80];
      pair.vx <= s_axis_tdata[127:96];
      pair.vy <= s_axis_tdata[159:128];
      pair.bx <= s_axis_tdata[191:160];
      pair.by <= s_axis_tdata[223:192];
      pair.bw <= s_axis_tdata[239:224];
      pair.bh <= s_axis_tdata[255:240];
    end
  end

  sac_front u_front (
    .clk   (clk),
    .en    (en),
    .pair  (pair),
    .front (front)
  );

  sac_div u_div_ex (.clk(clk), .en(en), .dist_in(front.x.din),  .vel(front.x.vel),
                    .entry(1'b1), .time_q(ex));
  sac_div u_div_xx (.clk(clk), .en(en), .dist_in(front.x.dout), .vel(front.x.vel),
                    .entry(1'b0), .time_q(xx));
  sac_div u_div_ey (.clk(clk), .en(en), .dist_in(front.y.din),  .vel(front.y.vel),
                    .entry(1'b1), .time_q(ey));
  sac_div u_div_xy (.clk(clk), .en(en), .dist_in(front.y.dout), .vel(front.y.vel),
                    .entry(1'b0), .time_q(xy));

  // The broad-phase answer and entry distance signs ride alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0].broad     <= front.broad;
      side_line[0].din_x_neg <= front.x.din[DIST_W-1];
      side_line[0].din_y_neg <= front.y.din[DIST_W-1];
      for (int k = 1; k < DIV_LAT; k++) begin
        side_line[k] <= side_line[k-1];
      end
    end
  end

  sac_decide u_decide (
    .clk  (clk),
    .en   (en),
    .ex   (ex),
    .ey   (ey),
    .xx   (xx),
    .xy   (xy),
    .side (side_line[DIV_LAT-1]),
    .res  (res)
  );

  assign m_axis_tdata = {1'b0, res.broad_overlap, res.normal_y, res.normal_x,
                         res.entry_time, res.hit};

endmodule
`default_nettype wire

// ===== sv/sac_front.sv =====
// Edge distances and broad-phase overlap stage.
`default_nettype none
module sac_front import sac_pkg::*; (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire pair_t  pair,
  output front_t      front
);

  function automatic logic signed [DIST_W-1:0] sx(input logic signed [POS_W-1:0] v);
    sx = {{(DIST_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  function automatic logic signed [DIST_W-1:0] fx(input logic [SIZE_W-1:0] s);
    fx = {{(DIST_W-SIZE_W-FRAC_W){1'b0}}, s, {FRAC_W{1'b0}}};
  endfunction

  function automatic axis_t axis_calc(input logic signed [POS_W-1:0] p,
                                      input logic [SIZE_W-1:0] s,
                                      input logic signed [POS_W-1:0] v,
                                      input logic signed [POS_W-1:0] bp,
                                      input logic [SIZE_W-1:0] bs);
    logic signed [DIST_W-1:0] near_d;
    logic signed [DIST_W-1:0] far_d;
    near_d = sx(bp) - (sx(p) + fx(s));
    far_d  = (sx(bp) + fx(bs)) - sx(p);
    axis_calc.vel = v;
    if (v > 0) begin
      axis_calc.din  = near_d;
      axis_calc.dout = far_d;
    end else begin
      axis_calc.din  = far_d;
      axis_calc.dout = near_d;
    end
  endfunction

  // Swept interval runs from p + min(v,0) to p + s + max(v,0); touching counts.
  function automatic logic axis_broad(input logic signed [POS_W-1:0] p,
                                      input logic [SIZE_W-1:0] s,
                                      input logic signed [POS_W-1:0] v,
                                      input logic signed [POS_W-1:0] bp,
                                      input logic [SIZE_W-1:0] bs);
    logic signed [DIST_W-1:0] lo;
    logic signed [DIST_W-1:0] hi;
    lo = sx(p) + ((v < 0) ? sx(v) : '0);
    hi = sx(p) + fx(s) + ((v > 0) ? sx(v) : '0);
    axis_broad = !((hi < sx(bp)) || ((sx(bp) + fx(bs)) < lo));
  endfunction

  front_t front_next;

  always_comb begin
    front_next.x = axis_calc(pair.mx, pair.mw, pair.vx, pair.bx, pair.bw);
    front_next.y = axis_calc(pair.my, pair.mh, pair.vy, pair.by, pair.bh);
    front_next.broad = axis_broad(pair.mx, pair.mw, pair.vx, pair.bx, pair.bw) &&
                       axis_broad(pair.my, pair.mh, pair.vy, pair.by, pair.bh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sac_div.sv =====
// Pipelined floor divider giving a saturated Q16.16 axis time, one quotient bit per stage.
`default_nettype none
module sac_div import sac_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DIST_W-1:0] dist_in,
  input  wire logic signed [POS_W-1:0]  vel,
  input  wire logic                     entry,
  output logic signed [TIME_W-1:0]      time_q
);

  typedef struct packed {
    logic neg;
    logic ovf;
    logic vzero;
    logic entry;
  } divf_t;

  logic [DEN_W-1:0] rem  [QBITS+1];
  logic [QBITS-1:0] low  [QBITS+1];
  logic [QBITS-1:0] quot [QBITS+1];
  logic [DEN_W-1:0] den  [QBITS+1];
  divf_t            flg  [QBITS+1];

  logic [DIST_W-1:0] dist_abs;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  vel_abs;
  logic [HIGH_W-1:0] high;
  logic [DEN_W:0]    trial [QBITS];
  logic [DEN_W:0]    diff  [QBITS];
  logic [QBITS:0]    magn;
  logic signed [TIME_W-1:0] time_next;

  always_comb begin
    dist_abs = dist_in[DIST_W-1] ? -dist_in : dist_in;
    num      = {dist_abs[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    vel_abs  = vel[POS_W-1] ? -vel : vel;
    high     = num[NUM_W-1:QBITS];
    for (int k = 0; k < QBITS; k++) begin
      trial[k] = {rem[k], low[k][QBITS-1]};
      diff[k]  = trial[k] - {1'b0, den[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]       <= {{(DEN_W-HIGH_W){1'b0}}, high};
      low[0]       <= num[QBITS-1:0];
      quot[0]      <= '0;
      den[0]       <= vel_abs;
      flg[0].neg   <= dist_in[DIST_W-1] ^ vel[POS_W-1];
      flg[0].ovf   <= {{(DEN_W-HIGH_W){1'b0}}, high} >= vel_abs;
      flg[0].vzero <= (vel == '0);
      flg[0].entry <= entry;
      for (int k = 0; k < QBITS; k++) begin
        if (trial[k] >= {1'b0, den[k]}) begin
          rem[k+1] <= diff[k][DEN_W-1:0];
        end else begin
          rem[k+1] <= trial[k][DEN_W-1:0];
        end
        low[k+1]  <= {low[k][QBITS-2:0], 1'b0};
        quot[k+1] <= {quot[k][QBITS-2:0], (trial[k] >= {1'b0, den[k]})};
        den[k+1]  <= den[k];
        flg[k+1]  <= flg[k];
      end
    end
  end

  // A negative quotient rounds toward minus infinity: magnitude grows by one
  // whenever the remainder is not zero.
  always_comb begin
    magn = {1'b0, quot[QBITS]} + {{QBITS{1'b0}}, (rem[QBITS] != '0)};
    if (flg[QBITS].vzero) begin
      time_next = flg[QBITS].entry ? T_MIN : T_MAX;
    end else if (flg[QBITS].neg) begin
      if (flg[QBITS].ovf || (magn > {{(QBITS+1-TIME_W){1'b0}}, T_MIN})) begin
        time_next = T_MIN;
      end else begin
        time_next = -magn[TIME_W-1:0];
      end
    end else begin
      if (flg[QBITS].ovf || (quot[QBITS] > {{(QBITS-TIME_W){1'b0}}, T_MAX})) begin
        time_next = T_MAX;
      end else begin
        time_next = quot[QBITS][TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      time_q <= time_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sac_decide.sv =====
// Final hit decision, entry time and contact normal stage.
`default_nettype none
module sac_decide import sac_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [TIME_W-1:0] ex,
  input  wire logic signed [TIME_W-1:0] ey,
  input  wire logic signed [TIME_W-1:0] xx,
  input  wire logic signed [TIME_W-1:0] xy,
  input  wire side_t                    side,
  output res_t                          res
);

  logic signed [TIME_W-1:0] tin;
  logic signed [TIME_W-1:0] tout;
  logic miss;
  res_t res_next;

  always_comb begin
    tin  = (ex > ey) ? ex : ey;
    tout = (xx < xy) ? xx : xy;
    miss = (tin > tout) || ((ex < 0) && (ey < 0)) || (ex > FIX_ONE) || (ey > FIX_ONE);
    res_next.broad_overlap = side.broad;
    res_next.hit        = 1'b0;
    res_next.entry_time = FIX_ONE[ET_W-1:0];
    res_next.normal_x   = NRM_ZERO;
    res_next.normal_y   = NRM_ZERO;
    if (!miss) begin
      res_next.hit        = 1'b1;
      res_next.entry_time = tin[ET_W-1:0];
      if (ex > ey) begin
        res_next.normal_x = side.din_x_neg ? NRM_POS : NRM_NEG;
      end else begin
        res_next.normal_y = side.din_y_neg ? NRM_POS : NRM_NEG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire
